// File: hw/rtl/wsa_pkg.sv
package wsa_pkg;

  // Fixed table geometry.
  localparam int MAX_BEARERS = 16;
  localparam int MAX_SLOTS_PER_BEARER = 16;
  localparam int SLOT_BATCH = 32;
  localparam int WEIGHT_BASE = 16;

  localparam int BIDX_W = 4;    // bearer index
  localparam int SIDX_W = 4;    // slot position inside one bearer list
  localparam int BUF_AW = 5;    // offered slot buffer address
  localparam int STORE_AW = BIDX_W + SIDX_W;
  localparam int DIV_W = 11;    // dividend width of weight * count
  localparam int REM_W = 10;

  // Command codes.
  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_REMOVE  = 3'd1;
  localparam logic [2:0] CMD_OFFER   = 3'd2;
  localparam logic [2:0] CMD_PREEMPT = 3'd3;
  localparam logic [2:0] CMD_REQUEST = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_ASSIGNED  = 3'd1;
  localparam logic [2:0] ST_SATISFIED = 3'd2;
  localparam logic [2:0] ST_REJECTED  = 3'd3;
  localparam logic [2:0] ST_NO_DONOR  = 3'd4;
  localparam logic [2:0] ST_REGISTERED = 3'd5;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] bearer_index;
    logic [1:0] qos_class;
    logic [7:0] slot_id;
    logic       last_slot;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  bearer_index_out;
    logic [3:0]  donor_index;
    logic [7:0]  slot_out;
    logic [15:0] pending_count;
    logic        last_result;
  } out_rsp_t;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_PASS_SUM,
    FSM_PASS_NEXT,
    FSM_PASS_DIV,
    FSM_PASS_LIM,
    FSM_PASS_RD,
    FSM_PASS_WR,
    FSM_PASS_DONE,
    FSM_SCAN,
    FSM_PRE_NODON,
    FSM_PRE_MV
  } fsm_t;

  // Class to priority mapping for newly added bearers.
  function automatic logic [3:0] class_priority(input logic [1:0] q);
    logic [3:0] p;
    case (q)
      2'd0: p = 4'd1;
      2'd1: p = 4'd5;
      2'd2: p = 4'd10;
      2'd3: p = 4'd15;
      default: p = 4'd15;
    endcase
    return p;
  endfunction

endpackage

// File: hw/rtl/weighted_slot_allocator.sv
// Channel   Ports                          Direction  Moves
// request   in_valid/in_ready/in_data      in         one command request
// result    out_valid/out_ready/out_data   out        one result item
// config    cfg_we/cfg_wdata               in         minimum slots for new bearers
//
// Add, remove, request, undefined commands and offers without the last mark are
// answered straight from the idle state. A preempt that needs a donor scans the bearer table for one.
// An offer with the last mark runs a pass: the weight sum over the bearer table,
// the serial divider per visited bearer (one quotient bit a cycle), and a buffer
// read and store write per assigned slot.
// Reset is synchronous and clears the table at once; the slot memories need no clearing.
// A stalled result holds the block at its next result-emitting step until it is taken.
module weighted_slot_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wsa_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output wsa_pkg::out_rsp_t out_data,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata
);

  // Control and table state.
  wsa_pkg::fsm_t state_r, state_nxt;
  logic [4:0]  active_r, active_nxt;
  logic [4:0]  cfg_min_r;
  logic [5:0]  fill_r, fill_nxt;
  logic [15:0] req_r, req_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [5:0]  used_r, used_nxt;
  logic [5:0]  n_r, n_nxt;
  logic [4:0]  i_r, i_nxt;
  logic [3:0]  h_r, h_nxt;
  logic [3:0]  best_r, best_nxt;
  logic [3:0]  bestp_r, bestp_nxt;
  logic [8:0]  tw_r, tw_nxt;
  logic [9:0]  rem_r, rem_nxt;
  logic [10:0] quo_r, quo_nxt;
  logic [3:0]  dstep_r, dstep_nxt;

  // Bearer table: one read address and one write address per cycle.
  logic [3:0] pri_r [wsa_pkg::MAX_BEARERS];
  logic [4:0] min_r [wsa_pkg::MAX_BEARERS];
  logic [4:0] tot_r [wsa_pkg::MAX_BEARERS];
  logic [3:0] tab_addr;
  logic [3:0] tab_pri;
  logic [4:0] tab_min, tab_tot;
  logic       tab_wr_all, tab_wr_tot;
  logic [3:0] tab_waddr;
  logic [3:0] tab_wpri;
  logic [4:0] tab_wmin, tab_wtot;

  // Slot memories.
  logic [7:0] store_mem [2**wsa_pkg::STORE_AW];
  logic       store_we, store_re;
  logic [7:0] store_waddr, store_raddr;
  logic [7:0] store_wdata, store_rdata_r;
  logic [7:0] obuf_mem [wsa_pkg::SLOT_BATCH];
  logic       obuf_we, obuf_re;
  logic [4:0] obuf_waddr, obuf_raddr;
  logic [7:0] obuf_wdata, obuf_rdata_r;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  wsa_pkg::out_rsp_t out_data_r, out_data_nxt;

  logic       can_emit, emit, emit_last;
  logic [2:0] emit_status;
  logic [3:0] emit_bidx, emit_donor;
  logic [7:0] emit_slot;
  logic       bidx_ok, room;
  logic [9:0] trial;
  logic [5:0] lim;
  logic [4:0] need;

  assign can_emit  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == wsa_pkg::FSM_IDLE) && can_emit;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Table read address follows the step in progress.
  always_comb begin
    case (state_r)
      wsa_pkg::FSM_IDLE:      tab_addr = in_data.bearer_index;
      wsa_pkg::FSM_SCAN:      tab_addr = (i_r < active_r) ? i_r[3:0] : best_r;
      wsa_pkg::FSM_PRE_NODON: tab_addr = h_r;
      wsa_pkg::FSM_PRE_MV:    tab_addr = h_r;
      default:                tab_addr = i_r[3:0];
    endcase
  end

  assign tab_pri = pri_r[tab_addr];
  assign tab_min = min_r[tab_addr];
  assign tab_tot = tot_r[tab_addr];
  assign bidx_ok = {1'b0, in_data.bearer_index} < active_r;
  assign room    = fill_r < 6'(wsa_pkg::SLOT_BATCH);
  assign trial   = {rem_r[8:0], quo_r[10]};

  always_comb begin
    state_nxt   = state_r;
    active_nxt  = active_r;
    fill_nxt    = fill_r;
    req_nxt     = req_r;
    cnt_nxt     = cnt_r;
    used_nxt    = used_r;
    n_nxt       = n_r;
    i_nxt       = i_r;
    h_nxt       = h_r;
    best_nxt    = best_r;
    bestp_nxt   = bestp_r;
    tw_nxt      = tw_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    dstep_nxt   = dstep_r;
    tab_wr_all  = 1'b0;
    tab_wr_tot  = 1'b0;
    tab_waddr   = tab_addr;
    tab_wpri    = '0;
    tab_wmin    = '0;
    tab_wtot    = '0;
    store_we    = 1'b0;
    store_re    = 1'b0;
    store_waddr = '0;
    store_raddr = '0;
    store_wdata = '0;
    obuf_we     = 1'b0;
    obuf_re     = 1'b0;
    obuf_waddr  = fill_r[4:0];
    obuf_raddr  = used_r[4:0];
    obuf_wdata  = in_data.slot_id;
    emit        = 1'b0;
    emit_last   = 1'b1;
    emit_status = wsa_pkg::ST_DONE;
    emit_bidx   = '0;
    emit_donor  = '0;
    emit_slot   = '0;
    lim         = '0;
    need        = '0;

    case (state_r)
      wsa_pkg::FSM_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_data.cmd)
            wsa_pkg::CMD_ADD: begin
              emit = 1'b1;
              if (active_r >= 5'(wsa_pkg::MAX_BEARERS)) begin
                emit_status = wsa_pkg::ST_REJECTED;
              end else begin
                tab_wr_all = 1'b1;
                tab_waddr  = active_r[3:0];
                tab_wpri   = wsa_pkg::class_priority(in_data.qos_class);
                tab_wmin   = cfg_min_r;
                active_nxt = active_r + 5'd1;
                emit_bidx  = active_r[3:0];
              end
            end
            wsa_pkg::CMD_REMOVE: begin
              emit      = 1'b1;
              emit_bidx = in_data.bearer_index;
              if (bidx_ok) begin
                tab_wr_all = 1'b1;
              end else begin
                emit_status = wsa_pkg::ST_REJECTED;
              end
            end
            wsa_pkg::CMD_OFFER: begin
              if (room) begin
                obuf_we  = 1'b1;
                fill_nxt = fill_r + 6'd1;
              end
              if (in_data.last_slot) begin
                cnt_nxt   = room ? fill_r + 6'd1 : fill_r;
                i_nxt     = '0;
                tw_nxt    = '0;
                state_nxt = wsa_pkg::FSM_PASS_SUM;
              end else begin
                emit = 1'b1;
                emit_status = room ? wsa_pkg::ST_DONE : wsa_pkg::ST_REJECTED;
              end
            end
            wsa_pkg::CMD_PREEMPT: begin
              emit_bidx = in_data.bearer_index;
              if (!bidx_ok) begin
                emit = 1'b1;
                emit_status = wsa_pkg::ST_REJECTED;
              end else if (tab_tot >= tab_min) begin
                emit = 1'b1;
                emit_status = wsa_pkg::ST_SATISFIED;
              end else if (tab_tot >= 5'(wsa_pkg::MAX_SLOTS_PER_BEARER)) begin
                emit = 1'b1;
                emit_status = wsa_pkg::ST_REJECTED;
              end else begin
                h_nxt     = in_data.bearer_index;
                i_nxt     = '0;
                best_nxt  = '0;
                bestp_nxt = '0;
                state_nxt = wsa_pkg::FSM_SCAN;
              end
            end
            wsa_pkg::CMD_REQUEST: begin
              emit      = 1'b1;
              emit_bidx = in_data.bearer_index;
              if (!bidx_ok) begin
                emit_status = wsa_pkg::ST_REJECTED;
              end else if (tab_tot >= tab_min) begin
                emit_status = wsa_pkg::ST_SATISFIED;
              end else begin
                if (req_r != 16'hFFFF) begin
                  req_nxt = req_r + 16'd1;
                end
                emit_status = wsa_pkg::ST_REGISTERED;
              end
            end
            default: begin
              emit        = 1'b1;
              emit_bidx   = in_data.bearer_index;
              emit_status = wsa_pkg::ST_REJECTED;
            end
          endcase
        end
      end

      // Sum of weights over all bearers ever added.
      wsa_pkg::FSM_PASS_SUM: begin
        if (i_r < active_r) begin
          tw_nxt = tw_r + 9'(5'(wsa_pkg::WEIGHT_BASE) - {1'b0, tab_pri});
          i_nxt  = i_r + 5'd1;
        end else if (tw_r == '0) begin
          state_nxt = wsa_pkg::FSM_PASS_DONE;
        end else begin
          i_nxt     = '0;
          used_nxt  = '0;
          state_nxt = wsa_pkg::FSM_PASS_NEXT;
        end
      end

      wsa_pkg::FSM_PASS_NEXT: begin
        if (i_r >= active_r || used_r >= cnt_r) begin
          state_nxt = wsa_pkg::FSM_PASS_DONE;
        end else begin
          quo_nxt   = 11'(5'(wsa_pkg::WEIGHT_BASE) - {1'b0, tab_pri}) * 11'(cnt_r);
          rem_nxt   = '0;
          dstep_nxt = '0;
          state_nxt = wsa_pkg::FSM_PASS_DIV;
        end
      end

      // Restoring divider, one quotient bit per cycle.
      wsa_pkg::FSM_PASS_DIV: begin
        if (trial >= {1'b0, tw_r}) begin
          rem_nxt = trial - {1'b0, tw_r};
          quo_nxt = {quo_r[9:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[9:0], 1'b0};
        end
        dstep_nxt = dstep_r + 4'd1;
        if (dstep_r == 4'(wsa_pkg::DIV_W - 1)) begin
          state_nxt = wsa_pkg::FSM_PASS_LIM;
        end
      end

      // Slots for this bearer: share, bounded by its need, the slots left
      // and the room in its list.
      wsa_pkg::FSM_PASS_LIM: begin
        lim = cnt_r - used_r;
        if (quo_r < 11'(lim)) begin
          lim = quo_r[5:0];
        end
        if (tab_min >= tab_tot) begin
          need = tab_min - tab_tot;
          if (6'(need) < lim) begin
            lim = 6'(need);
          end
        end
        if (tab_tot >= 5'(wsa_pkg::MAX_SLOTS_PER_BEARER)) begin
          lim = '0;
        end else if (6'(5'(wsa_pkg::MAX_SLOTS_PER_BEARER) - tab_tot) < lim) begin
          lim = 6'(5'(wsa_pkg::MAX_SLOTS_PER_BEARER) - tab_tot);
        end
        n_nxt = lim;
        if (lim == '0) begin
          i_nxt     = i_r + 5'd1;
          state_nxt = wsa_pkg::FSM_PASS_NEXT;
        end else begin
          state_nxt = wsa_pkg::FSM_PASS_RD;
        end
      end

      wsa_pkg::FSM_PASS_RD: begin
        obuf_re   = 1'b1;
        state_nxt = wsa_pkg::FSM_PASS_WR;
      end

      wsa_pkg::FSM_PASS_WR: begin
        if (can_emit) begin
          store_we    = 1'b1;
          store_waddr = {i_r[3:0], tab_tot[3:0]};
          store_wdata = obuf_rdata_r;
          tab_wr_tot  = 1'b1;
          tab_wtot    = tab_tot + 5'd1;
          used_nxt    = used_r + 6'd1;
          n_nxt       = n_r - 6'd1;
          emit        = 1'b1;
          emit_last   = 1'b0;
          emit_status = wsa_pkg::ST_ASSIGNED;
          emit_bidx   = i_r[3:0];
          emit_slot   = obuf_rdata_r;
          if (n_r == 6'd1) begin
            i_nxt     = i_r + 5'd1;
            state_nxt = wsa_pkg::FSM_PASS_NEXT;
          end else begin
            state_nxt = wsa_pkg::FSM_PASS_RD;
          end
        end
      end

      wsa_pkg::FSM_PASS_DONE: begin
        if (can_emit) begin
          emit      = 1'b1;
          fill_nxt  = '0;
          state_nxt = wsa_pkg::FSM_IDLE;
        end
      end

      // Donor search: highest priority among bearers holding excess.
      wsa_pkg::FSM_SCAN: begin
        if (i_r < active_r) begin
          if (i_r[3:0] != h_r && tab_tot > tab_min && tab_pri > bestp_r) begin
            bestp_nxt = tab_pri;
            best_nxt  = i_r[3:0];
          end
          i_nxt = i_r + 5'd1;
        end else if (bestp_r == '0) begin
          state_nxt = wsa_pkg::FSM_PRE_NODON;
        end else begin
          store_re    = 1'b1;
          store_raddr = {best_r, 4'(tab_tot - 5'd1)};
          tab_wr_tot  = 1'b1;
          tab_waddr   = best_r;
          tab_wtot    = tab_tot - 5'd1;
          state_nxt   = wsa_pkg::FSM_PRE_MV;
        end
      end

      wsa_pkg::FSM_PRE_NODON: begin
        if (can_emit) begin
          emit        = 1'b1;
          emit_status = wsa_pkg::ST_NO_DONOR;
          emit_bidx   = h_r;
          state_nxt   = wsa_pkg::FSM_IDLE;
        end
      end

      wsa_pkg::FSM_PRE_MV: begin
        if (can_emit) begin
          store_we    = 1'b1;
          store_waddr = {h_r, tab_tot[3:0]};
          store_wdata = store_rdata_r;
          tab_wr_tot  = 1'b1;
          tab_wtot    = tab_tot + 5'd1;
          emit        = 1'b1;
          emit_status = wsa_pkg::ST_ASSIGNED;
          emit_bidx   = h_r;
          emit_donor  = best_r;
          emit_slot   = store_rdata_r;
          state_nxt   = wsa_pkg::FSM_IDLE;
        end
      end

      default: begin
        state_nxt = wsa_pkg::FSM_IDLE;
      end
    endcase

    // The output register loads a new result or empties once taken.
    out_data_nxt = out_data_r;
    if (emit) begin
      out_valid_nxt                 = 1'b1;
      out_data_nxt.status           = emit_status;
      out_data_nxt.bearer_index_out = emit_bidx;
      out_data_nxt.donor_index      = emit_donor;
      out_data_nxt.slot_out         = emit_slot;
      out_data_nxt.pending_count    = req_nxt;
      out_data_nxt.last_result      = emit_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wsa_pkg::FSM_IDLE;
      active_r    <= '0;
      cfg_min_r   <= 5'd2;
      fill_r      <= '0;
      req_r       <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      n_r         <= '0;
      used_r      <= '0;
      cnt_r       <= '0;
      dstep_r     <= '0;
      for (int k = 0; k < wsa_pkg::MAX_BEARERS; k++) begin
        pri_r[k] <= '0;
        min_r[k] <= '0;
        tot_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      fill_r      <= fill_nxt;
      req_r       <= req_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      n_r         <= n_nxt;
      used_r      <= used_nxt;
      cnt_r       <= cnt_nxt;
      dstep_r     <= dstep_nxt;
      if (cfg_we) begin
        cfg_min_r <= cfg_wdata;
      end
      if (tab_wr_all) begin
        pri_r[tab_waddr] <= tab_wpri;
        min_r[tab_waddr] <= tab_wmin;
        tot_r[tab_waddr] <= tab_wtot;
      end else if (tab_wr_tot) begin
        tot_r[tab_waddr] <= tab_wtot;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    h_r        <= h_nxt;
    best_r     <= best_nxt;
    bestp_r    <= bestp_nxt;
    tw_r       <= tw_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    out_data_r <= out_data_nxt;
  end

  // Assigned slot lists, one row of sixteen per bearer.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= store_wdata;
    end
    if (store_re) begin
      store_rdata_r <= store_mem[store_raddr];
    end
  end

  // Slots offered since the last allocation pass.
  always_ff @(posedge clk) begin
    if (obuf_we) begin
      obuf_mem[obuf_waddr] <= obuf_wdata;
    end
    if (obuf_re) begin
      obuf_rdata_r <= obuf_mem[obuf_raddr];
    end
  end

  // The offered buffer never holds more than one batch.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 6'(wsa_pkg::SLOT_BATCH))
    else $error("offered fill beyond batch size");

  // The bearer count never passes the table size.
  a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r <= 5'(wsa_pkg::MAX_BEARERS))
    else $error("active bearer count beyond table size");

  // Each slot handed out in a pass consumes exactly one buffered slot.
  a_pass_consume: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wsa_pkg::FSM_PASS_WR && can_emit) |=> used_r == $past(used_r) + 6'd1)
    else $error("pass assignment did not consume a buffered slot");

  // A pass never hands out more slots than were offered.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wsa_pkg::FSM_PASS_RD) |-> used_r < cnt_r)
    else $error("pass read beyond offered slots");

  // The final result of a pass leaves the buffer empty.
  a_pass_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wsa_pkg::FSM_PASS_DONE && can_emit) |=> fill_r == '0)
    else $error("offered buffer not emptied after pass");

endmodule

// File: dv/weighted_slot_allocator_tb.sv
`timescale 1ns / 100ps

module weighted_slot_allocator_tb;

  // Command and class codes that the package leaves unnamed.
  localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;
  localparam logic [1:0] QOS_COMMAND  = 2'd0;
  localparam logic [1:0] QOS_VOICE    = 2'd1;
  localparam logic [1:0] QOS_POSITION = 2'd2;
  localparam logic [1:0] QOS_OTHER    = 2'd3;

  // Settling time long enough to cover any step still in flight.
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 300;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  wsa_pkg::in_req_t  in_data;
  logic              out_valid;
  logic              out_ready;
  wsa_pkg::out_rsp_t out_data;
  logic              cfg_we;
  logic [4:0]        cfg_wdata;

  weighted_slot_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the bearer table, kept in step with every accepted request.
  int unsigned n_bearers;
  logic [3:0]  prio_tbl [wsa_pkg::MAX_BEARERS];
  logic [4:0]  min_tbl  [wsa_pkg::MAX_BEARERS];
  logic [4:0]  held_tbl [wsa_pkg::MAX_BEARERS];
  logic [7:0]  slot_store [wsa_pkg::MAX_BEARERS*wsa_pkg::MAX_SLOTS_PER_BEARER];
  logic [7:0]  offer_buf [wsa_pkg::SLOT_BATCH];
  int unsigned offer_fill;
  logic [15:0] pending_reqs;
  logic [4:0]  min_setting;
  logic [3:0]  class_prio [4] = '{4'd1, 4'd5, 4'd10, 4'd15};

  // Results still owed by the block, oldest first.
  wsa_pkg::out_rsp_t due_results[$];

  int  errors;
  bit  quiet;      // no idling on either side while set
  bit  hold_now;   // asks the receiver for one long hold-off

  function automatic wsa_pkg::out_rsp_t rsp(logic [2:0] st, logic [3:0] b, logic [3:0] d,
                                            logic [7:0] s, logic [15:0] p, logic last);
    wsa_pkg::out_rsp_t o;
    o.status = st;
    o.bearer_index_out = b;
    o.donor_index = d;
    o.slot_out = s;
    o.pending_count = p;
    o.last_result = last;
    return o;
  endfunction

  // Weighted share pass over the bearer table, run when the last slot is offered.
  function automatic void share_offered_slots();
    int unsigned tw, used, w, need, share, t;
    logic [7:0] s;
    tw = 0;
    used = 0;
    for (int i = 0; i < n_bearers; i++) tw += wsa_pkg::WEIGHT_BASE - prio_tbl[i];
    if (tw != 0) begin
      for (int i = 0; i < n_bearers && used < offer_fill; i++) begin
        w = wsa_pkg::WEIGHT_BASE - prio_tbl[i];
        // A bearer already above its minimum has no cap on its need.
        need = (min_tbl[i] >= held_tbl[i]) ? min_tbl[i] - held_tbl[i] : 32'hFFFF_FFFF;
        share = (w * offer_fill) / tw;
        if (share > need) share = need;
        for (int j = 0; j < share && used < offer_fill; j++) begin
          t = held_tbl[i];
          if (t < wsa_pkg::MAX_SLOTS_PER_BEARER) begin
            s = offer_buf[used];
            used++;
            slot_store[i*wsa_pkg::MAX_SLOTS_PER_BEARER + t] = s;
            held_tbl[i] = 5'(t + 1);
            due_results.push_back(rsp(wsa_pkg::ST_ASSIGNED, 4'(i), 4'd0, s, pending_reqs,
                                      1'b0));
          end
        end
      end
    end
    offer_fill = 0;
    due_results.push_back(rsp(wsa_pkg::ST_DONE, 4'd0, 4'd0, 8'd0, pending_reqs, 1'b1));
  endfunction

  function automatic void preempt_slot(logic [3:0] h);
    int unsigned best, top, dt;
    bit found;
    logic [7:0] s;
    best = 0;
    top = 0;
    found = 0;
    if (held_tbl[h] >= min_tbl[h]) begin
      due_results.push_back(rsp(wsa_pkg::ST_SATISFIED, h, 4'd0, 8'd0, pending_reqs, 1'b1));
    end else if (held_tbl[h] >= wsa_pkg::MAX_SLOTS_PER_BEARER) begin
      due_results.push_back(rsp(wsa_pkg::ST_REJECTED, h, 4'd0, 8'd0, pending_reqs, 1'b1));
    end else begin
      // Donor is the highest priority bearer holding excess; the first one wins ties.
      for (int i = 0; i < n_bearers; i++) begin
        if (i != h && held_tbl[i] > min_tbl[i] && prio_tbl[i] > top) begin
          top = prio_tbl[i];
          best = i;
          found = 1;
        end
      end
      if (!found) begin
        due_results.push_back(rsp(wsa_pkg::ST_NO_DONOR, h, 4'd0, 8'd0, pending_reqs, 1'b1));
      end else begin
        dt = held_tbl[best] - 1;
        s = slot_store[best*wsa_pkg::MAX_SLOTS_PER_BEARER +
                       (dt % wsa_pkg::MAX_SLOTS_PER_BEARER)];
        held_tbl[best] = 5'(dt);
        slot_store[h*wsa_pkg::MAX_SLOTS_PER_BEARER + held_tbl[h]] = s;
        held_tbl[h] = held_tbl[h] + 5'd1;
        due_results.push_back(rsp(wsa_pkg::ST_ASSIGNED, h, 4'(best), s, pending_reqs, 1'b1));
      end
    end
  endfunction

  // Updates the shadow table for one accepted request and queues its results.
  function automatic void apply_command(wsa_pkg::in_req_t r);
    logic [3:0] b;
    bit room;
    b = r.bearer_index;
    case (r.cmd)
      wsa_pkg::CMD_ADD: begin
        if (n_bearers >= wsa_pkg::MAX_BEARERS) begin
          due_results.push_back(rsp(wsa_pkg::ST_REJECTED, 4'd0, 4'd0, 8'd0, pending_reqs,
                                    1'b1));
        end else begin
          prio_tbl[n_bearers] = class_prio[r.qos_class];
          min_tbl[n_bearers] = min_setting;
          held_tbl[n_bearers] = '0;
          due_results.push_back(rsp(wsa_pkg::ST_DONE, 4'(n_bearers), 4'd0, 8'd0,
                                    pending_reqs, 1'b1));
          n_bearers++;
        end
      end
      wsa_pkg::CMD_REMOVE: begin
        if (b >= n_bearers) begin
          due_results.push_back(rsp(wsa_pkg::ST_REJECTED, b, 4'd0, 8'd0, pending_reqs, 1'b1));
        end else begin
          // The entry stays counted, now with weight 16 and no minimum.
          prio_tbl[b] = '0;
          min_tbl[b] = '0;
          held_tbl[b] = '0;
          due_results.push_back(rsp(wsa_pkg::ST_DONE, b, 4'd0, 8'd0, pending_reqs, 1'b1));
        end
      end
      wsa_pkg::CMD_OFFER: begin
        room = offer_fill < wsa_pkg::SLOT_BATCH;
        if (room) begin
          offer_buf[offer_fill] = r.slot_id;
          offer_fill++;
        end
        if (r.last_slot) begin
          share_offered_slots();
        end else begin
          due_results.push_back(rsp(room ? wsa_pkg::ST_DONE : wsa_pkg::ST_REJECTED, 4'd0,
                                    4'd0, 8'd0, pending_reqs, 1'b1));
        end
      end
      wsa_pkg::CMD_PREEMPT: begin
        if (b >= n_bearers) begin
          due_results.push_back(rsp(wsa_pkg::ST_REJECTED, b, 4'd0, 8'd0, pending_reqs, 1'b1));
        end else begin
          preempt_slot(b);
        end
      end
      wsa_pkg::CMD_REQUEST: begin
        if (b >= n_bearers) begin
          due_results.push_back(rsp(wsa_pkg::ST_REJECTED, b, 4'd0, 8'd0, pending_reqs, 1'b1));
        end else if (held_tbl[b] >= min_tbl[b]) begin
          due_results.push_back(rsp(wsa_pkg::ST_SATISFIED, b, 4'd0, 8'd0, pending_reqs, 1'b1));
        end else begin
          if (pending_reqs != 16'hFFFF) pending_reqs++;
          due_results.push_back(rsp(wsa_pkg::ST_REGISTERED, b, 4'd0, 8'd0, pending_reqs,
                                    1'b1));
        end
      end
      default: begin
        due_results.push_back(rsp(wsa_pkg::ST_REJECTED, b, 4'd0, 8'd0, pending_reqs, 1'b1));
      end
    endcase
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Result monitor: every accepted result is checked against the oldest one owed.
  always @(posedge clk) begin
    wsa_pkg::out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report("unexpected result, status", int'(out_data.status), -1);
      end else begin
        want = due_results.pop_front();
        if (out_data.status !== want.status)
          report("status", int'(out_data.status), int'(want.status));
        if (out_data.bearer_index_out !== want.bearer_index_out)
          report("bearer_index_out", int'(out_data.bearer_index_out),
                 int'(want.bearer_index_out));
        if (out_data.donor_index !== want.donor_index)
          report("donor_index", int'(out_data.donor_index), int'(want.donor_index));
        if (out_data.slot_out !== want.slot_out)
          report("slot_out", int'(out_data.slot_out), int'(want.slot_out));
        if (out_data.pending_count !== want.pending_count)
          report("pending_count", int'(out_data.pending_count), int'(want.pending_count));
        if (out_data.last_result !== want.last_result)
          report("last_result", int'(out_data.last_result), int'(want.last_result));
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // block backs up and drops in_ready while the sender keeps offering.
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_now) begin
        hold_now = 0;
        out_ready <= 1'b0;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(posedge clk);
          n++;
        end
      end else if (!quiet && $urandom_range(5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one request and returns once it is accepted. Valid is left high so
  // a following request can go out back to back.
  task automatic send(input wsa_pkg::in_req_t r);
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_command(r);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
  endtask

  // Register writes happen only once the block has drained and settled.
  task automatic write_min(input logic [4:0] v);
    drop_valid();
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_setting = v;
  endtask

  function automatic wsa_pkg::in_req_t req(logic [2:0] c, logic [3:0] b, logic [1:0] q,
                                           logic [7:0] s, logic last);
    wsa_pkg::in_req_t r;
    r.cmd = c;
    r.bearer_index = b;
    r.qos_class = q;
    r.slot_id = s;
    r.last_slot = last;
    return r;
  endfunction

  function automatic logic [3:0] pick_bearer();
    if (n_bearers > 0 && $urandom_range(4) != 0) return 4'($urandom_range(0, n_bearers - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  typedef struct {
    wsa_pkg::in_req_t  r;
    bit                typed;
    wsa_pkg::out_rsp_t want;
  } step_t;

  step_t steps[$];

  task automatic random_phase(input int count);
    int done;
    int len;
    int pick;
    wsa_pkg::in_req_t r;
    done = 0;
    while (done < count) begin
      r = wsa_pkg::in_req_t'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // Mostly well formed offer batches; some overflow the buffer, some
        // leave off the last mark and spill into the next batch.
        len = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          r = wsa_pkg::in_req_t'($urandom);
          r.cmd = wsa_pkg::CMD_OFFER;
          r.last_slot = (k == len - 1) && ($urandom_range(7) != 0);
          send(r);
          done++;
        end
      end else if (pick < 50) begin
        r.cmd = wsa_pkg::CMD_ADD;
        send(r);
        done++;
      end else if (pick < 58) begin
        r.cmd = wsa_pkg::CMD_REMOVE;
        r.bearer_index = pick_bearer();
        send(r);
        done++;
      end else if (pick < 78) begin
        r.cmd = wsa_pkg::CMD_PREEMPT;
        r.bearer_index = pick_bearer();
        send(r);
        done++;
      end else if (pick < 98) begin
        r.cmd = wsa_pkg::CMD_REQUEST;
        r.bearer_index = pick_bearer();
        send(r);
        done++;
      end else begin
        r.cmd = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
        send(r);
        done++;
      end
    end
  endtask

  initial begin
    // Reset state of the shadow table.
    n_bearers = 0;
    offer_fill = 0;
    pending_reqs = '0;
    min_setting = 5'd2;
    for (int i = 0; i < wsa_pkg::MAX_BEARERS; i++) begin
      prio_tbl[i] = '0;
      min_tbl[i] = '0;
      held_tbl[i] = '0;
    end
    errors = 0;
    quiet = 0;
    hold_now = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests. Results that are plain from the table state are typed
    // in; the rest come from the shadow table.
    steps = '{
      '{req(wsa_pkg::CMD_REQUEST, 4'd0, QOS_COMMAND, 8'd0, 1'b0), 1,
        rsp(wsa_pkg::ST_REJECTED, 4'd0, 4'd0, 8'd0, 16'd0, 1'b1)},
      '{req(wsa_pkg::CMD_OFFER, 4'd0, QOS_COMMAND, 8'hFF, 1'b1), 1,
        rsp(wsa_pkg::ST_DONE, 4'd0, 4'd0, 8'd0, 16'd0, 1'b1)},
      '{req(CMD_UNDEF_HI, 4'd15, QOS_OTHER, 8'hFF, 1'b1), 1,
        rsp(wsa_pkg::ST_REJECTED, 4'd15, 4'd0, 8'd0, 16'd0, 1'b1)},
      '{req(wsa_pkg::CMD_ADD, 4'd9, QOS_COMMAND, 8'd0, 1'b0), 1,
        rsp(wsa_pkg::ST_DONE, 4'd0, 4'd0, 8'd0, 16'd0, 1'b1)},
      '{req(wsa_pkg::CMD_ADD, 4'd0, QOS_OTHER, 8'd0, 1'b0), 1,
        rsp(wsa_pkg::ST_DONE, 4'd1, 4'd0, 8'd0, 16'd0, 1'b1)},
      '{req(wsa_pkg::CMD_ADD, 4'd0, QOS_VOICE, 8'd0, 1'b0), 1,
        rsp(wsa_pkg::ST_DONE, 4'd2, 4'd0, 8'd0, 16'd0, 1'b1)},
      '{req(wsa_pkg::CMD_ADD, 4'd0, QOS_POSITION, 8'd0, 1'b0), 1,
        rsp(wsa_pkg::ST_DONE, 4'd3, 4'd0, 8'd0, 16'd0, 1'b1)},
      '{req(wsa_pkg::CMD_REQUEST, 4'd1, QOS_COMMAND, 8'd0, 1'b0), 1,
        rsp(wsa_pkg::ST_REGISTERED, 4'd1, 4'd0, 8'd0, 16'd1, 1'b1)},
      '{req(wsa_pkg::CMD_PREEMPT, 4'd0, QOS_COMMAND, 8'd0, 1'b0), 1,
        rsp(wsa_pkg::ST_NO_DONOR, 4'd0, 4'd0, 8'd0, 16'd1, 1'b1)},
      '{req(wsa_pkg::CMD_OFFER, 4'd0, QOS_COMMAND, 8'h00, 1'b0), 1,
        rsp(wsa_pkg::ST_DONE, 4'd0, 4'd0, 8'd0, 16'd1, 1'b1)},
      '{req(wsa_pkg::CMD_OFFER, 4'd0, QOS_COMMAND, 8'hAA, 1'b0), 1,
        rsp(wsa_pkg::ST_DONE, 4'd0, 4'd0, 8'd0, 16'd1, 1'b1)},
      '{req(wsa_pkg::CMD_OFFER, 4'd0, QOS_COMMAND, 8'h55, 1'b0), 1,
        rsp(wsa_pkg::ST_DONE, 4'd0, 4'd0, 8'd0, 16'd1, 1'b1)},
      '{req(wsa_pkg::CMD_REMOVE, 4'd2, QOS_COMMAND, 8'd0, 1'b0), 1,
        rsp(wsa_pkg::ST_DONE, 4'd2, 4'd0, 8'd0, 16'd1, 1'b1)},
      '{req(wsa_pkg::CMD_REMOVE, 4'd9, QOS_COMMAND, 8'd0, 1'b0), 1,
        rsp(wsa_pkg::ST_REJECTED, 4'd9, 4'd0, 8'd0, 16'd1, 1'b1)},
      '{req(wsa_pkg::CMD_PREEMPT, 4'd12, QOS_COMMAND, 8'd0, 1'b0), 1,
        rsp(wsa_pkg::ST_REJECTED, 4'd12, 4'd0, 8'd0, 16'd1, 1'b1)},
      '{req(wsa_pkg::CMD_OFFER, 4'd0, QOS_COMMAND, 8'hFF, 1'b1), 0, '0},
      '{req(wsa_pkg::CMD_PREEMPT, 4'd3, QOS_COMMAND, 8'd0, 1'b0), 0, '0},
      '{req(wsa_pkg::CMD_PREEMPT, 4'd1, QOS_COMMAND, 8'd0, 1'b0), 0, '0},
      '{req(wsa_pkg::CMD_REQUEST, 4'd0, QOS_COMMAND, 8'd0, 1'b0), 0, '0},
      '{req(CMD_UNDEF_LO, 4'd5, QOS_COMMAND, 8'd0, 1'b0), 0, '0},
      '{req(wsa_pkg::CMD_ADD, 4'd15, QOS_OTHER, 8'd0, 1'b1), 0, '0}
    };
    foreach (steps[i]) begin
      send(steps[i].r);
      if (steps[i].typed) begin
        void'(due_results.pop_back());
        due_results.push_back(steps[i].want);
      end
    end

    // Random phases at several minimum settings, the extremes among them.
    write_min(5'd0);
    random_phase(90);
    hold_now = 1;
    random_phase(30);
    write_min(5'd16);
    random_phase(100);
    write_min(5'($urandom_range(1, 15)));
    random_phase(40);
    quiet = 1;
    random_phase(40);

    drop_valid();
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS weighted_slot_allocator");
    end else begin
      $display("FAIL weighted_slot_allocator");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("FAIL weighted_slot_allocator");
    $finish;
  end

endmodule
